FILE: src/u2d_pkg.sv
// shared types, constants and a helper function for the binary to decimal digit unit
package u2d_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned NUM_DIGITS = 20;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned RADIX      = 10;
    localparam int unsigned WIDE_W     = VALUE_W + DIGIT_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

    // powers of ten, index is the exponent
    localparam logic [VALUE_W-1:0] POW10 [0:NUM_DIGITS-1] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000,
        64'd100000000000000000,
        64'd1000000000000000000,
        64'd10000000000000000000
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } out_item_t;

    // state carried down the digit pipeline
    typedef struct packed {
        logic [VALUE_W-1:0]                   rest;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;
        logic [IDX_W-1:0]                     first;
        logic                                 started;
    } stage_t;

    // d times the place weight of digit position pos (pos 0 is most significant)
    function automatic logic [WIDE_W-1:0] place_multiple(int unsigned pos, int unsigned d);
        logic [WIDE_W-1:0] weight;
        weight = {{DIGIT_W{1'b0}}, POW10[NUM_DIGITS-1-pos]};
        return WIDE_W'(d) * weight;
    endfunction

endpackage

FILE: src/u2d_stream_if.sv
// valid/ready stream channel with a generic payload
interface u2d_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/u64_to_decimal_digits_unit.sv
// top level of the unsigned 64-bit to decimal digit stream converter
//
// value_ch carries one request per item: an unsigned 64-bit value. digit_ch
// returns that value's decimal digits, most significant first, one digit per
// transfer, leading zeros dropped; zero gives a single 0. last marks the
// units digit. Both channels transfer on a clock edge with valid and ready high.
//
// Twenty pipeline stages each settle one digit, from the 10^19 place down;
// a request may enter on every cycle while nothing is stalled. A request
// passes the stage registers, the digit buffer and the output register
// before its first digit is valid on digit_ch. Throughput is set by the
// output: one digit per cycle while the receiver is ready, n digits (1 to
// 20) per value, and value_ch requests are taken back to back as digits drain.
//
// A stalled receiver fills the output register, then the digit buffer, then
// the pipeline stages one by one; ready on value_ch drops only when all are
// full, and nothing is lost or repeated. Reset clears all valid flags.
module u64_to_decimal_digits_unit (
    input  logic          clk,
    input  logic          rst_n,
    u2d_stream_if.sink    value_ch,
    u2d_stream_if.source  digit_ch
);
    import u2d_pkg::*;

    // pipeline boundaries, index 0 is the input side
    stage_t             bnd_data  [0:NUM_DIGITS];
    logic [NUM_DIGITS:0] bnd_valid;
    logic [NUM_DIGITS:0] bnd_ready;

    stage_t    seed;
    out_item_t out_data;
    logic      out_valid;

    // seed the pipeline: nothing found yet, so a zero value points at the units digit
    always_comb
    begin
        seed         = '0;
        seed.rest    = value_ch.payload.value;
        seed.first   = LAST_IDX;
        seed.started = 1'b0;
    end
    assign bnd_data[0]    = seed;
    assign bnd_valid[0]   = value_ch.valid;
    assign value_ch.ready = bnd_ready[0];

    // one stage per decimal place
    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_stage
        u2d_digit_stage #(
            .POS (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_data  (bnd_data[k]),
            .up_valid (bnd_valid[k]),
            .up_ready (bnd_ready[k]),
            .dn_data  (bnd_data[k+1]),
            .dn_valid (bnd_valid[k+1]),
            .dn_ready (bnd_ready[k+1])
        );
    end

    // digit buffer and output register
    u2d_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_data   (bnd_data[NUM_DIGITS]),
        .up_valid  (bnd_valid[NUM_DIGITS]),
        .up_ready  (bnd_ready[NUM_DIGITS]),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (digit_ch.ready)
    );

    assign digit_ch.valid         = out_valid;
    assign digit_ch.payload.digit = out_data.digit;
    assign digit_ch.payload.last  = out_data.last;

endmodule

FILE: src/u2d_digit_stage.sv
// one pipeline stage that settles a single decimal digit
module u2d_digit_stage #(
    parameter int unsigned POS = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  u2d_pkg::stage_t up_data,
    input  logic            up_valid,
    output logic            up_ready,
    output u2d_pkg::stage_t dn_data,
    output logic            dn_valid,
    input  logic            dn_ready
);
    import u2d_pkg::*;

    stage_t             stage_reg;
    stage_t             stage_next;
    logic               valid_reg;
    logic [DIGIT_W-1:0] digit;
    logic [WIDE_W-1:0]  sub;

    // largest multiple of the place weight that fits in the remainder
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int unsigned d = 1; d < RADIX; d++)
        begin
            if ({{DIGIT_W{1'b0}}, up_data.rest} >= place_multiple(POS, d))
            begin
                digit = DIGIT_W'(d);
                sub   = place_multiple(POS, d);
            end
        end
        stage_next             = up_data;
        stage_next.rest        = up_data.rest - sub[VALUE_W-1:0];
        stage_next.digits[POS] = digit;
        if (!up_data.started && digit != '0)
        begin
            stage_next.started = 1'b1;
            stage_next.first   = IDX_W'(POS);
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_data  = stage_reg;
    assign dn_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

FILE: src/u2d_serializer.sv
// holds one converted value and streams its digits out, one per cycle while the receiver is ready
module u2d_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  u2d_pkg::stage_t    up_data,
    input  logic               up_valid,
    output logic               up_ready,
    output u2d_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    import u2d_pkg::*;

    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_reg;
    logic [IDX_W-1:0]                   idx_reg;
    logic                               busy_reg;
    out_item_t                          out_reg;
    logic                               out_valid_reg;

    logic out_load;
    logic emit;
    logic final_emit;
    logic take;

    assign out_load   = !out_valid_reg || out_ready;
    assign emit       = busy_reg && out_load;
    assign final_emit = emit && (idx_reg == LAST_IDX);
    assign up_ready   = !busy_reg || final_emit;
    assign take       = up_valid && up_ready;

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
            end
            else if (final_emit)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            digits_reg <= up_data.digits;
            idx_reg    <= up_data.first;
        end
        else if (emit)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (emit)
        begin
            out_reg.digit <= digits_reg[idx_reg];
            out_reg.last  <= (idx_reg == LAST_IDX);
        end
    end

endmodule
